// ===== src/mpsg_pkg.sv =====
// Package for the modular power sequence generator.
// Holds the field widths, parameter defaults, result status codes and FSM states.
// No dependencies.
package mpsg_pkg;

  localparam int VALUE_WIDTH_DEF        = 32;
  localparam int MAX_GROUPS_DEF         = 5;
  localparam int ELEMENTS_PER_GROUP_DEF = 12;

  localparam int FIELD_W   = 32;
  localparam int COUNT_W   = 3;
  localparam int IDX_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 72;

  localparam logic [FIELD_W-1:0] SEED_RESET = FIELD_W'(119);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ELEMENT     = 2'd0,
    STATUS_BAD_MODULUS = 2'd1,
    STATUS_EMPTY       = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EMIT,
    ST_MUL,
    ST_STATUS
  } state_t;

endpackage

// ===== src/modular_power_sequence_gen_unit.sv =====
// Modular power sequence generator: emits g*tau^i mod p for one job at a time.
// Bit-serial modular reduction and multiplication on one shared accumulator.
// Depends on mpsg_pkg.
//
// channel   | direction | content
// ----------+-----------+--------------------------------------------------------
// s_axis    | in        | job: modulus, start_value, group_count
// m_axis    | out       | result: element, element_index, verify_key; tuser status; tlast
// cfg       | in        | write of multiplier_seed, loads the kept multiplier
//
// A job with modulus 0 or 1 goes straight to the status state and returns a bad-modulus status.
// Otherwise the kept multiplier is first reduced modulo p-1 (an empty job then returns an
// empty status); each element is emitted from the emit state, each later one after a serial
// multiply by the reduced multiplier modulo p.
// Reset clears the FSM and the output valid and loads the kept multiplier with 119.
// A stalled output holds the FSM in its emit or status state; one job is in flight at a time.
module modular_power_sequence_gen_unit #(
  parameter int VALUE_WIDTH        = mpsg_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_GROUPS         = mpsg_pkg::MAX_GROUPS_DEF,
  parameter int ELEMENTS_PER_GROUP = mpsg_pkg::ELEMENTS_PER_GROUP_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // modulus [31:0], start_value [63:32], group_count [66:64], zero pad above
  input  logic [mpsg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // element [31:0], element_index [37:32], verify_key [69:38], zero pad above
  output logic [mpsg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status [1:0]
  output logic [mpsg_pkg::STATUS_W-1:0]       m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [mpsg_pkg::FIELD_W-1:0]        cfg_wdata
);

  localparam int W   = VALUE_WIDTH;
  localparam int CW  = $clog2(VALUE_WIDTH);
  localparam int XW  = VALUE_WIDTH + 2;
  localparam int IW  = mpsg_pkg::IDX_W;
  localparam int FW  = mpsg_pkg::FIELD_W;
  localparam int GW  = mpsg_pkg::COUNT_W;

  mpsg_pkg::state_t  state, state_next;

  logic [W-1:0]   kept;
  logic [W-1:0]   mod_p;
  logic [W-1:0]   mod_m;
  logic [W-1:0]   acc;
  logic [W-1:0]   opnd;
  logic [W-1:0]   elem;
  logic [W-1:0]   key;
  logic [CW-1:0]  bit_cnt;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  total;
  mpsg_pkg::status_t job_status;

  logic                      out_valid;
  logic [W-1:0]              out_element;
  logic [IW-1:0]             out_index;
  logic [W-1:0]              out_key;
  mpsg_pkg::status_t         out_status;
  logic                      out_last;

  logic [W-1:0]   p_in;
  logic [W-1:0]   g_in;
  logic [GW-1:0]  groups_in;
  logic [GW-1:0]  groups_sat;
  logic           accept;
  logic           out_free;
  logic           bit_done;
  logic           is_final;
  logic           emit_elem;
  logic           emit_status;
  logic [W-1:0]   addend;
  logic [XW-1:0]  sum;
  logic [XW-1:0]  m1;
  logic [XW-1:0]  m2;
  logic [XW-1:0]  sum_red;
  logic [W-1:0]   acc_next;

  assign p_in      = s_axis_tdata[W-1:0];
  assign g_in      = s_axis_tdata[FW +: W];
  assign groups_in = s_axis_tdata[2*FW +: GW];
  assign groups_sat = (groups_in > GW'(MAX_GROUPS)) ? GW'(MAX_GROUPS) : groups_in;

  assign s_axis_tready = (state == mpsg_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign bit_done      = (bit_cnt == '0);
  assign is_final      = (idx == total - IW'(1));

  // Shared serial step: acc = (2*acc + bit*addend) mod m, with addend <= m.
  assign addend   = (state == mpsg_pkg::ST_REDUCE) ? W'(opnd[W-1]) :
                    (opnd[W-1] ? kept : '0);
  assign sum      = XW'({acc, 1'b0}) + XW'(addend);
  assign m1       = XW'(mod_m);
  assign m2       = XW'({mod_m, 1'b0});
  assign sum_red  = (sum >= m2) ? (sum - m2) : ((sum >= m1) ? (sum - m1) : sum);
  assign acc_next = sum_red[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    emit_elem   = 1'b0;
    emit_status = 1'b0;
    case (state)
      mpsg_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (p_in <= W'(1)) ? mpsg_pkg::ST_STATUS : mpsg_pkg::ST_REDUCE;
        end
      end
      mpsg_pkg::ST_REDUCE: begin
        if (bit_done) begin
          state_next = (total == '0) ? mpsg_pkg::ST_STATUS : mpsg_pkg::ST_EMIT;
        end
      end
      mpsg_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_elem  = 1'b1;
          state_next = is_final ? mpsg_pkg::ST_IDLE : mpsg_pkg::ST_MUL;
        end
      end
      mpsg_pkg::ST_MUL: begin
        if (bit_done) begin
          state_next = mpsg_pkg::ST_EMIT;
        end
      end
      mpsg_pkg::ST_STATUS: begin
        if (out_free) begin
          emit_status = 1'b1;
          state_next  = mpsg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mpsg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= mpsg_pkg::SEED_RESET[W-1:0];
    end else if (cfg_we) begin
      kept <= cfg_wdata[W-1:0];
    end else if ((state == mpsg_pkg::ST_REDUCE) && bit_done) begin
      kept <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mod_p      <= p_in;
      mod_m      <= p_in - W'(1);
      elem       <= g_in;
      key        <= '0;
      idx        <= '0;
      acc        <= '0;
      opnd       <= kept;
      bit_cnt    <= CW'(W - 1);
      total      <= IW'(groups_sat * ELEMENTS_PER_GROUP);
      job_status <= (p_in <= W'(1)) ? mpsg_pkg::STATUS_BAD_MODULUS : mpsg_pkg::STATUS_EMPTY;
    end else if ((state == mpsg_pkg::ST_REDUCE) || (state == mpsg_pkg::ST_MUL)) begin
      acc     <= acc_next;
      opnd    <= {opnd[W-2:0], 1'b0};
      bit_cnt <= bit_cnt - CW'(1);
      if ((state == mpsg_pkg::ST_MUL) && bit_done) begin
        elem <= acc_next;
      end
    end else if (emit_elem) begin
      if (idx == IW'(1)) begin
        key <= elem;
      end
      acc     <= '0;
      opnd    <= elem;
      mod_m   <= mod_p;
      bit_cnt <= CW'(W - 1);
      idx     <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_elem || emit_status) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_elem) begin
      out_element <= elem;
      out_index   <= idx;
      out_status  <= mpsg_pkg::STATUS_ELEMENT;
      out_last    <= is_final;
      out_key     <= !is_final ? '0 : ((idx == IW'(1)) ? elem : key);
    end else if (emit_status) begin
      out_element <= '0;
      out_index   <= '0;
      out_status  <= job_status;
      out_last    <= 1'b1;
      out_key     <= '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(mpsg_pkg::OUT_DATA_W - 2*FW - IW)'(0),
                          FW'(out_key), out_index, FW'(out_element)};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  a_acc_below_modulus: assert property (@(posedge clk) disable iff (rst)
    ((state == mpsg_pkg::ST_REDUCE) || (state == mpsg_pkg::ST_MUL)) |-> (acc < mod_m))
    else $error("serial accumulator not reduced below modulus");

  a_tau_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == mpsg_pkg::ST_MUL) |-> (kept < mod_m))
    else $error("multiplier not reduced below modulus during multiply");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != mpsg_pkg::STATUS_ELEMENT)) |-> m_axis_tlast)
    else $error("status result without last flag");

  a_job_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != mpsg_pkg::ST_IDLE))
    else $error("accepted job dropped");

endmodule
